// File: sv/cursor_line_edit_buffer_macros.svh
// Assertion macros used by the line edit buffer checker.
`ifndef CURSOR_LINE_EDIT_BUFFER_MACROS_SVH
`define CURSOR_LINE_EDIT_BUFFER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CLEB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cleb: same-cycle property failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CLEB_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cleb: next-cycle property failed");

`endif

// File: sv/cleb_pkg.sv
// Package for the line edit buffer: sizes, command codes, FSM states and control structs.
package cleb_pkg;

    localparam int CAPACITY = 256;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int LEN_W    = 9;
    localparam int MOVED_W  = 10;
    localparam int CHAR_W   = 8;
    localparam int AMT_W    = 10;
    localparam int CMD_W    = 3;
    localparam int RIDX_W   = 8;
    localparam int CALC_W   = 11;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT   = 3'd0,
        CMD_SEEK_SET = 3'd1,
        CMD_SEEK_REL = 3'd2,
        CMD_SEEK_END = 3'd3,
        CMD_DELETE   = 3'd4,
        CMD_CLEAR    = 3'd5,
        CMD_READ     = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE,
        ST_PUT,
        ST_CAPT,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic put;
        logic capt;
        logic publish;
    } ctrl_t;

    // Datapath to controller
    typedef struct packed {
        logic count_zero;
        logic op_read;
        logic op_put;
    } stat_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [CHAR_W-1:0]        char_in;
        logic signed [AMT_W-1:0]  amount;
        logic [RIDX_W-1:0]        read_index;
    } item_t;

    typedef struct packed {
        logic signed [MOVED_W-1:0] moved;
        logic [LEN_W-1:0]          text_len;
        logic [LEN_W-1:0]          cursor;
        logic [CHAR_W-1:0]         char_out;
        logic                      full_res;
    } result_t;

endpackage

// File: sv/cleb_if.sv
// Valid/ready channel interfaces for command input and result output.
interface cleb_in_if;
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic [7:0]        char_in;
    logic signed [9:0] amount;
    logic [7:0]        read_index;

    modport source (output valid, output command, output char_in, output amount,
                    output read_index, input ready);
    modport sink   (input valid, input command, input char_in, input amount,
                    input read_index, output ready);
endinterface

interface cleb_out_if;
    logic              valid;
    logic              ready;
    logic signed [9:0] moved;
    logic [8:0]        text_len;
    logic [8:0]        cursor;
    logic [7:0]        char_out;
    logic              full_res;

    modport source (output valid, output moved, output text_len, output cursor,
                    output char_out, output full_res, input ready);
    modport sink   (input valid, input moved, input text_len, input cursor,
                    input char_out, input full_res, output ready);
endinterface

// File: sv/cleb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cleb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, reads every cycle
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/cleb_ctrl.sv
// Controller FSM: sequences accept, tail shift, insert write, read capture and result hand-off.
module cleb_ctrl import cleb_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output ctrl_t ctrl
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                if (stat.count_zero)
                begin
                    if (stat.op_read)
                    begin
                        state_next = ST_CAPT;
                    end
                    else if (stat.op_put)
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_PUT:    state_next = ST_FINISH;
            ST_CAPT:   state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        ctrl.load    = (state_reg == ST_IDLE) && in_valid;
        ctrl.step    = (state_reg == ST_MOVE) && !stat.count_zero;
        ctrl.put     = (state_reg == ST_PUT);
        ctrl.capt    = (state_reg == ST_CAPT);
        ctrl.publish = (state_reg == ST_FINISH) && out_free;
        if (ctrl.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: sv/cleb_datapath.sv
// Datapath: length and cursor arithmetic, text RAM with pipelined tail shifter, result register.
module cleb_datapath import cleb_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  ctrl_t   ctrl,
    output stat_t   stat,
    input  item_t   item,
    output result_t res
);

    // Line state
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   cur_reg, cur_next;
    // Shift sequencer
    logic [ADDR_W-1:0]  src_reg, src_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [ADDR_W-1:0]  delta_reg, delta_next;
    logic               down_reg, down_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [ADDR_W-1:0]  put_addr_reg, put_addr_next;
    logic [CHAR_W-1:0]  ch_reg, ch_next;
    logic               op_read_reg, op_read_next;
    logic               op_put_reg, op_put_next;
    // Per-item results
    logic [MOVED_W-1:0] moved_reg, moved_next;
    logic               full_reg, full_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    // Output register
    result_t            res_reg, res_next;

    logic signed [CALC_W-1:0] amt_s, cur_s, rel_s, neg_s;
    logic [LEN_W-1:0]   set_tgt, rel_tgt, room, n_back, n_fwd;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CHAR_W-1:0]  ram_wdata;
    logic [CHAR_W-1:0]  ram_rdata;

    function automatic logic [LEN_W-1:0] clamp_line(input logic signed [CALC_W-1:0] v,
                                                    input logic [LEN_W-1:0] len);
        logic signed [CALC_W-1:0] len_ext;
        len_ext = $signed({{(CALC_W-LEN_W){1'b0}}, len});
        if (v < 0)
        begin
            return '0;
        end
        else if (v > len_ext)
        begin
            return len;
        end
        else
        begin
            return v[LEN_W-1:0];
        end
    endfunction

    // Seek and delete amounts
    assign amt_s   = CALC_W'(item.amount);
    assign cur_s   = $signed({{(CALC_W-LEN_W){1'b0}}, cur_reg});
    assign rel_s   = cur_s + amt_s;
    assign neg_s   = -amt_s;
    assign set_tgt = clamp_line(amt_s, len_reg);
    assign rel_tgt = clamp_line(rel_s, len_reg);
    assign room    = len_reg - cur_reg;
    assign n_back  = (neg_s > cur_s) ? cur_reg : neg_s[LEN_W-1:0];
    assign n_fwd   = (amt_s > $signed({{(CALC_W-LEN_W){1'b0}}, room}))
                     ? room : amt_s[LEN_W-1:0];

    // Command decode and shift sequencing
    always_comb
    begin
        len_next       = len_reg;
        cur_next       = cur_reg;
        src_next       = src_reg;
        cnt_next       = cnt_reg;
        delta_next     = delta_reg;
        down_next      = down_reg;
        pend_next      = ctrl.step;
        pend_addr_next = pend_addr_reg;
        put_addr_next  = put_addr_reg;
        ch_next        = ch_reg;
        op_read_next   = op_read_reg;
        op_put_next    = op_put_reg;
        moved_next     = moved_reg;
        full_next      = full_reg;
        char_next      = char_reg;
        res_next       = res_reg;

        if (ctrl.load)
        begin
            moved_next   = '0;
            full_next    = 1'b0;
            char_next    = '0;
            cnt_next     = '0;
            op_read_next = 1'b0;
            op_put_next  = 1'b0;
            unique case (cmd_t'(item.command))
                CMD_INSERT:
                begin
                    if (len_reg >= LEN_W'(CAPACITY))
                    begin
                        full_next = 1'b1;
                    end
                    else
                    begin
                        // shift tail right, top byte first
                        src_next      = ADDR_W'(len_reg - 1'b1);
                        cnt_next      = room;
                        delta_next    = ADDR_W'(1);
                        down_next     = 1'b1;
                        put_addr_next = ADDR_W'(cur_reg);
                        ch_next       = item.char_in;
                        op_put_next   = 1'b1;
                        len_next      = len_reg + 1'b1;
                        cur_next      = cur_reg + 1'b1;
                    end
                end
                CMD_SEEK_SET:
                begin
                    cur_next   = set_tgt;
                    moved_next = MOVED_W'({1'b0, set_tgt} - {1'b0, cur_reg});
                end
                CMD_SEEK_REL:
                begin
                    cur_next   = rel_tgt;
                    moved_next = MOVED_W'({1'b0, rel_tgt} - {1'b0, cur_reg});
                end
                CMD_SEEK_END:
                begin
                    cur_next   = len_reg;
                    moved_next = MOVED_W'({1'b0, len_reg} - {1'b0, cur_reg});
                end
                CMD_DELETE:
                begin
                    if (amt_s < 0)
                    begin
                        // backspace: tail from cursor moves down by n
                        src_next   = ADDR_W'(cur_reg);
                        cnt_next   = (n_back == '0) ? '0 : room;
                        delta_next = ADDR_W'(-n_back);
                        down_next  = 1'b0;
                        len_next   = len_reg - n_back;
                        cur_next   = cur_reg - n_back;
                        moved_next = MOVED_W'(n_back);
                    end
                    else if (amt_s > 0)
                    begin
                        // forward delete: tail past the removed bytes moves down
                        src_next   = ADDR_W'(cur_reg + n_fwd);
                        cnt_next   = room - n_fwd;
                        delta_next = ADDR_W'(-n_fwd);
                        down_next  = 1'b0;
                        len_next   = len_reg - n_fwd;
                        moved_next = MOVED_W'(n_fwd);
                    end
                end
                CMD_CLEAR:
                begin
                    len_next = '0;
                    cur_next = '0;
                end
                CMD_READ:
                begin
                    src_next     = ADDR_W'(item.read_index);
                    op_read_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        else if (ctrl.step)
        begin
            // read at src now; its data is written to src + delta next cycle
            pend_addr_next = src_reg + delta_reg;
            src_next       = down_reg ? (src_reg - 1'b1) : (src_reg + 1'b1);
            cnt_next       = cnt_reg - 1'b1;
        end

        if (ctrl.capt)
        begin
            char_next = ({1'b0, src_reg} < len_reg) ? ram_rdata : '0;
        end

        if (ctrl.publish)
        begin
            res_next.moved    = $signed(moved_reg);
            res_next.text_len = len_reg;
            res_next.cursor   = cur_reg;
            res_next.char_out = char_reg;
            res_next.full_res = full_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            cur_reg     <= '0;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            op_read_reg <= 1'b0;
            op_put_reg  <= 1'b0;
        end
        else
        begin
            len_reg     <= len_next;
            cur_reg     <= cur_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            op_read_reg <= op_read_next;
            op_put_reg  <= op_put_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        src_reg       <= src_next;
        delta_reg     <= delta_next;
        down_reg      <= down_next;
        pend_addr_reg <= pend_addr_next;
        put_addr_reg  <= put_addr_next;
        ch_reg        <= ch_next;
        moved_reg     <= moved_next;
        full_reg      <= full_next;
        char_reg      <= char_next;
        res_reg       <= res_next;
    end

    // Text store write mux: inserted byte or shifted byte
    assign ram_we    = pend_reg || ctrl.put;
    assign ram_waddr = ctrl.put ? put_addr_reg : pend_addr_reg;
    assign ram_wdata = ctrl.put ? ch_reg : ram_rdata;

    cleb_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (CAPACITY)
    ) u_text_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    assign stat.count_zero = (cnt_reg == '0);
    assign stat.op_read    = op_read_reg;
    assign stat.op_put     = op_put_reg;
    assign res             = res_reg;

endmodule

// File: sv/cursor_line_edit_buffer.sv
// Each transaction is accepted, then shifts the tail of the line in the RAM (insert and delete only),
// then writes the inserted byte (insert) or captures the read byte (read), then publishes its result.
// One transaction in flight; the next is taken in the cycle the previous result turns valid.
// The tail shift moves one byte per cycle through the RAM write port.
// The output register holds a result until taken. Reset (rst_n low, async) empties the line
// and puts the cursor at 0; text RAM contents are not cleared.
module cursor_line_edit_buffer import cleb_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    cleb_in_if.sink    in_ch,
    cleb_out_if.source out_ch
);

    ctrl_t   ctrl;
    stat_t   stat;
    item_t   item;
    result_t res;

    // Pack the input transaction
    assign item.command    = in_ch.command;
    assign item.char_in    = in_ch.char_in;
    assign item.amount     = in_ch.amount;
    assign item.read_index = in_ch.read_index;

    cleb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    cleb_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat),
        .item  (item),
        .res   (res)
    );

    // Unpack the result transaction
    assign out_ch.moved    = res.moved;
    assign out_ch.text_len = res.text_len;
    assign out_ch.cursor   = res.cursor;
    assign out_ch.char_out = res.char_out;
    assign out_ch.full_res = res.full_res;

endmodule

// File: sv/cleb_checker.sv
// Port-level checker for the line edit buffer, bound to the top level.
`include "cursor_line_edit_buffer_macros.svh"

module cleb_checker import cleb_pkg::*; (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [MOVED_W-1:0] moved,
    input logic [LEN_W-1:0]          text_len,
    input logic [LEN_W-1:0]          cursor,
    input logic [CHAR_W-1:0]         char_out,
    input logic                      full_res
);

    // Cursor never passes the end of the line
    `CLEB_ASSERT_IMP(a_cursor_in_line, out_valid, cursor <= text_len)
    // Length never exceeds capacity
    `CLEB_ASSERT_IMP(a_len_in_cap, out_valid, text_len <= LEN_W'(CAPACITY))
    // A dropped insert only happens on a full line and reports nothing else
    `CLEB_ASSERT_IMP(a_full_clean, out_valid && full_res, (moved == '0) && (char_out == '0) && (text_len == LEN_W'(CAPACITY)))
    // One transaction in flight: no accept right after an accept
    `CLEB_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
    // Stalled result holds
    `CLEB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(text_len) && $stable(cursor))

endmodule

bind cursor_line_edit_buffer cleb_checker u_cleb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .moved     (out_ch.moved),
    .text_len  (out_ch.text_len),
    .cursor    (out_ch.cursor),
    .char_out  (out_ch.char_out),
    .full_res  (out_ch.full_res)
);

// File: verif/cursor_line_edit_buffer_tb.sv
`timescale 1ns / 1ps
// Testbench for the line edit buffer: directed and random command streams checked against a model.
module cursor_line_edit_buffer_tb;
    import cleb_pkg::*;

    localparam logic [CMD_W-1:0]         CMD_UNUSED   = 3'd7;
    localparam logic signed [AMT_W-1:0]  AMT_MIN      = 10'sh200;
    localparam logic signed [AMT_W-1:0]  AMT_MAX      = 10'sh1FF;
    localparam int                       RANDOM_ITEMS = 380;
    localparam int                       HOLD_CYCLES  = 400;
    localparam int                       STALL_LIMIT  = 4000;
    localparam int                       IDLE_PCT     = 29;
    localparam int                       REPORT_MAX   = 10;
    localparam int                       TAIL_CYCLES  = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    cleb_in_if  in_ch ();
    cleb_out_if out_ch ();

    cursor_line_edit_buffer dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predicted line contents, length and cursor
    logic [CHAR_W-1:0] line_bytes [CAPACITY];
    logic [LEN_W-1:0]  line_len;
    logic [LEN_W-1:0]  line_cur;

    result_t pending_results [$];
    result_t seen;
    result_t wanted;
    int      error_count;
    int      stall_cycles;
    bit      idle_on;
    bit      hold_pending;

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one command to the predicted line and return the result it gives
    function automatic result_t edit_line(item_t it);
        result_t r;
        int len;
        int cur;
        int amt;
        int target;
        int n;
        r   = '0;
        len = line_len;
        cur = line_cur;
        amt = $signed(it.amount);
        n   = 0;
        case (it.command)
            CMD_INSERT:
            begin
                if (len >= CAPACITY)
                    r.full_res = 1'b1;
                else
                begin
                    for (int i = len; i > cur; i--)
                        line_bytes[i] = line_bytes[i-1];
                    line_bytes[cur] = it.char_in;
                    cur++;
                    len++;
                end
            end
            CMD_SEEK_SET, CMD_SEEK_REL:
            begin
                target = (it.command == CMD_SEEK_SET) ? amt : cur + amt;
                if (target < 0)
                    target = 0;
                else if (target > len)
                    target = len;
                r.moved = MOVED_W'(target - cur);
                cur     = target;
            end
            CMD_SEEK_END:
            begin
                r.moved = MOVED_W'(len - cur);
                cur     = len;
            end
            CMD_DELETE:
            begin
                // backspace for negative amounts, forward delete for positive
                if (amt < 0)
                begin
                    n = -amt;
                    if (n > cur)
                        n = cur;
                    for (int i = cur - n; i + n < len; i++)
                        line_bytes[i] = line_bytes[i+n];
                    len -= n;
                    cur -= n;
                end
                else if (amt > 0)
                begin
                    n = amt;
                    if (n > len - cur)
                        n = len - cur;
                    for (int i = cur; i + n < len; i++)
                        line_bytes[i] = line_bytes[i+n];
                    len -= n;
                end
                r.moved = MOVED_W'(n);
            end
            CMD_CLEAR:
            begin
                len = 0;
                cur = 0;
            end
            CMD_READ:
            begin
                if (int'(it.read_index) < len)
                    r.char_out = line_bytes[it.read_index];
            end
            default:
            begin
            end
        endcase
        line_len   = LEN_W'(len);
        line_cur   = LEN_W'(cur);
        r.text_len = LEN_W'(len);
        r.cursor   = LEN_W'(cur);
        return r;
    endfunction

    function automatic string fmt_result(result_t r);
        return $sformatf("moved=%0d len=%0d cursor=%0d char=%02h full=%0b",
                         $signed(r.moved), r.text_len, r.cursor, r.char_out, r.full_res);
    endfunction

    function automatic logic [CHAR_W-1:0] rand_byte();
        return CHAR_W'($urandom_range(255));
    endfunction

    // Mostly offsets near the line, some extremes and raw 10-bit values
    function automatic logic signed [AMT_W-1:0] pick_amount();
        int r;
        int span;
        r    = $urandom_range(99);
        span = int'(line_len) + 4;
        if (r < 10)
            return AMT_W'($urandom());
        else if (r < 20)
        begin
            case ($urandom_range(7))
                0:       return AMT_MIN;
                1:       return -10'sd256;
                2:       return -10'sd1;
                3:       return 10'sd0;
                4:       return 10'sd1;
                5:       return 10'sd256;
                6:       return AMT_MAX;
                default: return AMT_W'(-span);
            endcase
        end
        else if (r < 55)
            return AMT_W'(int'($urandom_range(16)) - 8);
        return AMT_W'(int'($urandom_range(2 * span)) - span);
    endfunction

    // Mostly an index inside the line, sometimes anywhere
    function automatic logic [RIDX_W-1:0] pick_index();
        if (line_len == 0 || $urandom_range(4) == 0)
            return RIDX_W'($urandom_range(255));
        return RIDX_W'($urandom_range(int'(line_len) - 1));
    endfunction

    // Offer one command, wait for its transaction and record the prediction
    task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                                 input logic signed [AMT_W-1:0] amt,
                                 input logic [RIDX_W-1:0] ridx);
        item_t it;
        @(negedge clk);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.command    <= cmd;
        in_ch.char_in    <= ch;
        in_ch.amount     <= amt;
        in_ch.read_index <= ridx;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        it.command    = cmd;
        it.char_in    = ch;
        it.amount     = amt;
        it.read_index = ridx;
        pending_results.push_back(edit_line(it));
    endtask

    // Sender pause until every outstanding result has come back
    task automatic wait_results_drained();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_line();
        issue_command(CMD_READ, 8'h00, 10'sd0, 8'd0);
        issue_command(CMD_SEEK_END, 8'h00, AMT_MIN, 8'd0);
        issue_command(CMD_DELETE, 8'h00, 10'sd0, 8'd0);
        issue_command(CMD_UNUSED, 8'hFF, AMT_MAX, 8'hFF);
        issue_command(CMD_SEEK_REL, 8'h00, -10'sd256, 8'd0);
    endtask

    task automatic test_insert_read();
        issue_command(CMD_INSERT, 8'h00, 10'sd0, 8'd0);
        issue_command(CMD_INSERT, 8'hFF, 10'sd0, 8'd0);
        issue_command(CMD_INSERT, 8'hA5, 10'sd0, 8'd0);
        // insert in the middle shifts the tail
        issue_command(CMD_SEEK_SET, 8'h00, 10'sd1, 8'd0);
        issue_command(CMD_INSERT, 8'h5A, 10'sd0, 8'd0);
        issue_command(CMD_READ, 8'h00, 10'sd0, 8'd1);
        issue_command(CMD_READ, 8'h00, 10'sd0, 8'd3);
        issue_command(CMD_READ, 8'h00, 10'sd0, 8'd4);
        issue_command(CMD_READ, 8'h00, 10'sd0, 8'd255);
    endtask

    task automatic test_seek_limits();
        issue_command(CMD_SEEK_SET, 8'h00, AMT_MIN, 8'd0);
        issue_command(CMD_SEEK_SET, 8'h00, AMT_MAX, 8'd0);
        issue_command(CMD_SEEK_REL, 8'h00, -10'sd256, 8'd0);
        issue_command(CMD_SEEK_REL, 8'h00, 10'sd256, 8'd0);
        issue_command(CMD_SEEK_END, 8'h00, AMT_MIN, 8'd0);
        issue_command(CMD_SEEK_SET, 8'h00, 10'sd2, 8'd0);
    endtask

    task automatic test_delete_limits();
        // backspace past the start, zero delete, forward delete past the end
        issue_command(CMD_DELETE, 8'h00, -10'sd256, 8'd0);
        issue_command(CMD_DELETE, 8'h00, 10'sd0, 8'd0);
        issue_command(CMD_DELETE, 8'h00, AMT_MAX, 8'd0);
        issue_command(CMD_INSERT, 8'h3C, 10'sd0, 8'd0);
        issue_command(CMD_CLEAR, 8'h00, 10'sd0, 8'd0);
        issue_command(CMD_READ, 8'h00, 10'sd0, 8'd0);
    endtask

    // Receiver holds off for a long stretch while commands keep coming
    task automatic test_output_stall();
        bit saved;
        saved        = idle_on;
        idle_on      = 1'b0;
        hold_pending = 1'b1;
        repeat (6)
            issue_command(CMD_INSERT, rand_byte(), 10'sd0, 8'd0);
        issue_command(CMD_SEEK_SET, 8'h00, 10'sd0, 8'd0);
        issue_command(CMD_INSERT, rand_byte(), 10'sd0, 8'd0);
        issue_command(CMD_READ, 8'h00, 10'sd0, 8'd3);
        idle_on = saved;
        wait_results_drained();
    endtask

    task automatic test_full_line();
        issue_command(CMD_CLEAR, rand_byte(), 10'sd0, 8'd0);
        while (line_len < CAPACITY)
        begin
            if ($urandom_range(15) == 0)
                issue_command(CMD_SEEK_SET, rand_byte(),
                              AMT_W'($urandom_range(int'(line_len))), 8'd0);
            issue_command(CMD_INSERT, rand_byte(), pick_amount(), pick_index());
        end
        // inserts into a full line are dropped
        issue_command(CMD_INSERT, 8'hFF, 10'sd0, 8'd0);
        issue_command(CMD_SEEK_SET, 8'h00, 10'sd0, 8'd0);
        issue_command(CMD_INSERT, 8'h00, 10'sd0, 8'd0);
        issue_command(CMD_READ, 8'h00, 10'sd0, 8'd255);
        repeat (4)
            issue_command(CMD_READ, rand_byte(), pick_amount(), pick_index());
        issue_command(CMD_SEEK_END, 8'h00, 10'sd0, 8'd0);
        issue_command(CMD_SEEK_REL, 8'h00, -10'sd256, 8'd0);
        issue_command(CMD_DELETE, 8'h00, 10'sd256, 8'd0);
    endtask

    task automatic test_random_edits();
        int               done;
        int               goal;
        int               r;
        logic [CMD_W-1:0] cmd;
        done = 0;
        while (done < RANDOM_ITEMS)
        begin
            // each session aims at a line length, mostly short
            goal = ($urandom_range(7) == 0) ? $urandom_range(256, 160) : $urandom_range(40);
            repeat ($urandom_range(60, 20))
            begin
                if (line_len < goal && $urandom_range(99) < 60)
                    cmd = CMD_INSERT;
                else
                begin
                    r = $urandom_range(99);
                    if (r < 20)
                        cmd = CMD_INSERT;
                    else if (r < 30)
                        cmd = CMD_SEEK_SET;
                    else if (r < 40)
                        cmd = CMD_SEEK_REL;
                    else if (r < 45)
                        cmd = CMD_SEEK_END;
                    else if (r < 65)
                        cmd = CMD_DELETE;
                    else if (r < 93)
                        cmd = CMD_READ;
                    else if (r < 96)
                        cmd = CMD_CLEAR;
                    else
                        cmd = CMD_UNUSED;
                end
                issue_command(cmd, rand_byte(), pick_amount(), pick_index());
                done++;
                // a stretch with no idling on either side
                if (done == RANDOM_ITEMS / 3)
                    idle_on = 1'b0;
                else if (done == RANDOM_ITEMS / 2)
                    idle_on = 1'b1;
            end
        end
    endtask

    // Result receiver: random ready, or a long counted hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_ch.ready <= 1'b0;
                for (int k = 0; k < HOLD_CYCLES; k++)
                    @(negedge clk);
            end
            else if (idle_on)
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            seen.moved    = out_ch.moved;
            seen.text_len = out_ch.text_len;
            seen.cursor   = out_ch.cursor;
            seen.char_out = out_ch.char_out;
            seen.full_res = out_ch.full_res;
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected result transaction: %s", fmt_result(seen));
            end
            else
            begin
                wanted = pending_results.pop_front();
                if (seen !== wanted)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display("result mismatch: expected %s, got %s",
                                 fmt_result(wanted), fmt_result(seen));
                end
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("cursor_line_edit_buffer_tb: done, errors");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        in_ch.valid      = 1'b0;
        in_ch.command    = CMD_INSERT;
        in_ch.char_in    = '0;
        in_ch.amount     = '0;
        in_ch.read_index = '0;
        line_len         = '0;
        line_cur         = '0;
        error_count      = 0;
        stall_cycles     = 0;
        idle_on          = 1'b1;
        hold_pending     = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_line();
        test_insert_read();
        test_seek_limits();
        test_delete_limits();
        test_output_stall();
        test_full_line();
        test_random_edits();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("cursor_line_edit_buffer_tb: done, clean");
        else
            $display("cursor_line_edit_buffer_tb: done, errors");
        $finish;
    end

endmodule
